// ===== src/erw_pkg.sv =====
// Shared types and codes for the edge reservation work area block.
package erw_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SumW   = CoordW + 1;
  localparam int unsigned EdgeW  = CoordW + 2;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [OpW-1:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_TOP    = 3'd2,
    OP_BOTTOM = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AREA_LEFT   = 3'd0,
    CFG_AREA_TOP    = 3'd1,
    CFG_AREA_WIDTH  = 3'd2,
    CFG_AREA_HEIGHT = 3'd3,
    CFG_ROOT_WIDTH  = 3'd4,
    CFG_ROOT_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [EdgeW-1:0] edge_pos;
    logic [SumW-1:0]         lo;
    logic [SumW-1:0]         hi;
    logic [SumW-1:0]         span_lo;
    logic [SumW-1:0]         span_hi;
    logic [CoordW-1:0]       s0;
    logic [CoordW-1:0]       s1;
    logic                    far_side;
  } side_geo_t;

endpackage

// ===== src/erw_side_max.sv =====
// Running maximum of the reservation on one side of the screen area.
module erw_side_max (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic                         clr_i,
  input  erw_pkg::side_geo_t           geo_i,
  output logic [erw_pkg::CoordW-1:0]   max_o
);

  logic [erw_pkg::CoordW-1:0]        max_q, max_d;
  logic                              edge_in;
  logic                              span_ok;
  logic [erw_pkg::SumW-1:0]          ov_lo, ov_hi;
  logic signed [erw_pkg::EdgeW-1:0]  lo_s, hi_s, amount;
  logic [erw_pkg::CoordW-1:0]        amount_c;

  always_comb begin
    lo_s = $signed({1'b0, geo_i.lo});
    hi_s = $signed({1'b0, geo_i.hi});
    edge_in = (geo_i.edge_pos >= lo_s) && (geo_i.edge_pos <= hi_s);
    ov_lo = ({1'b0, geo_i.s0} > geo_i.span_lo) ? {1'b0, geo_i.s0} : geo_i.span_lo;
    ov_hi = ({1'b0, geo_i.s1} < geo_i.span_hi) ? {1'b0, geo_i.s1} : geo_i.span_hi;
    span_ok = ov_hi > ov_lo;
    amount = geo_i.far_side ? (hi_s - geo_i.edge_pos) : (geo_i.edge_pos - lo_s);
    amount_c = amount[erw_pkg::CoordW-1:0];
  end

  always_comb begin
    max_d = max_q;
    if (clr_i) begin
      max_d = '0;
    end else if (upd_i && edge_in && span_ok && (amount_c > max_q)) begin
      max_d = amount_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

// ===== src/edge_reservation_workarea.sv =====
// Top level of the edge reservation work area block.
// Takes one item per cycle on the input channel while no finish item waits. An
// accepted item is held in an input register and evaluated there against the four
// side maxima. A finish item passes from the input register into the result
// register, which offers its result on the output channel. A finish item waits in
// the input register only while the result register holds an untaken result;
// reservation items never wait. Configuration writes are registered and apply to
// the item evaluated after them.
module edge_reservation_workarea (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [erw_pkg::OpW-1:0]             operation_i,
  input  logic [erw_pkg::CoordW-1:0]          extent_i,
  input  logic [erw_pkg::CoordW-1:0]          span_start_i,
  input  logic [erw_pkg::CoordW-1:0]          span_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [erw_pkg::SumW-1:0]            work_x_o,
  output logic [erw_pkg::SumW-1:0]            work_y_o,
  output logic signed [erw_pkg::EdgeW-1:0]    work_w_o,
  output logic signed [erw_pkg::EdgeW-1:0]    work_h_o,
  input  logic                                cfg_we_i,
  input  logic [erw_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [erw_pkg::CoordW-1:0]          cfg_wdata_i
);

  logic [erw_pkg::CoordW-1:0] area_left_q, area_top_q, area_width_q, area_height_q;
  logic [erw_pkg::CoordW-1:0] root_width_q, root_height_q;

  logic                       stg_valid_q, stg_valid_d;
  erw_pkg::op_e               stg_op_q;
  logic [erw_pkg::CoordW-1:0] stg_ext_q, stg_s0_q, stg_s1_q;

  logic                       out_valid_q, out_valid_d;
  logic [erw_pkg::SumW-1:0]   work_x_q, work_y_q;
  logic [erw_pkg::EdgeW-1:0]  work_w_q, work_h_q;

  logic in_xfer, adv, fin_adv;
  logic [erw_pkg::CoordW-1:0] max_left, max_right, max_top, max_bottom;
  erw_pkg::side_geo_t geo_left, geo_right, geo_top, geo_bottom;
  logic [erw_pkg::SumW-1:0] x_hi, y_hi;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q   <= '0;
      area_top_q    <= '0;
      area_width_q  <= '0;
      area_height_q <= '0;
      root_width_q  <= '0;
      root_height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        erw_pkg::CFG_AREA_LEFT:   area_left_q   <= cfg_wdata_i;
        erw_pkg::CFG_AREA_TOP:    area_top_q    <= cfg_wdata_i;
        erw_pkg::CFG_AREA_WIDTH:  area_width_q  <= cfg_wdata_i;
        erw_pkg::CFG_AREA_HEIGHT: area_height_q <= cfg_wdata_i;
        erw_pkg::CFG_ROOT_WIDTH:  root_width_q  <= cfg_wdata_i;
        erw_pkg::CFG_ROOT_HEIGHT: root_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  assign adv = stg_valid_q &&
               ((stg_op_q != erw_pkg::OP_FINISH) || !out_valid_q || out_ready_i);
  assign fin_adv    = adv && (stg_op_q == erw_pkg::OP_FINISH);
  assign in_ready_o = !stg_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_xfer) begin
      stg_valid_d = 1'b1;
    end else if (adv) begin
      stg_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fin_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stg_op_q  <= erw_pkg::op_e'(operation_i);
      stg_ext_q <= extent_i;
      stg_s0_q  <= span_start_i;
      stg_s1_q  <= span_end_i;
    end
  end

  // Side geometry
  assign x_hi = {1'b0, area_left_q} + {1'b0, area_width_q};
  assign y_hi = {1'b0, area_top_q} + {1'b0, area_height_q};

  always_comb begin
    geo_left.edge_pos = $signed({2'b00, stg_ext_q});
    geo_left.lo       = {1'b0, area_left_q};
    geo_left.hi       = x_hi;
    geo_left.span_lo  = {1'b0, area_top_q};
    geo_left.span_hi  = y_hi;
    geo_left.s0       = stg_s0_q;
    geo_left.s1       = stg_s1_q;
    geo_left.far_side = 1'b0;

    geo_right          = geo_left;
    geo_right.edge_pos = $signed({2'b00, root_width_q}) - $signed({2'b00, stg_ext_q});
    geo_right.far_side = 1'b1;

    geo_top.edge_pos = $signed({2'b00, stg_ext_q});
    geo_top.lo       = {1'b0, area_top_q};
    geo_top.hi       = y_hi;
    geo_top.span_lo  = {1'b0, area_left_q};
    geo_top.span_hi  = x_hi;
    geo_top.s0       = stg_s0_q;
    geo_top.s1       = stg_s1_q;
    geo_top.far_side = 1'b0;

    geo_bottom          = geo_top;
    geo_bottom.edge_pos = $signed({2'b00, root_height_q}) - $signed({2'b00, stg_ext_q});
    geo_bottom.far_side = 1'b1;
  end

  erw_side_max u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv && (stg_op_q == erw_pkg::OP_LEFT)),
    .clr_i  (fin_adv),
    .geo_i  (geo_left),
    .max_o  (max_left)
  );

  erw_side_max u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv && (stg_op_q == erw_pkg::OP_RIGHT)),
    .clr_i  (fin_adv),
    .geo_i  (geo_right),
    .max_o  (max_right)
  );

  erw_side_max u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv && (stg_op_q == erw_pkg::OP_TOP)),
    .clr_i  (fin_adv),
    .geo_i  (geo_top),
    .max_o  (max_top)
  );

  erw_side_max u_bottom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv && (stg_op_q == erw_pkg::OP_BOTTOM)),
    .clr_i  (fin_adv),
    .geo_i  (geo_bottom),
    .max_o  (max_bottom)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (fin_adv) begin
      work_x_q <= {1'b0, area_left_q} + {1'b0, max_left};
      work_y_q <= {1'b0, area_top_q} + {1'b0, max_top};
      work_w_q <= {2'b00, area_width_q} - {2'b00, max_left} - {2'b00, max_right};
      work_h_q <= {2'b00, area_height_q} - {2'b00, max_top} - {2'b00, max_bottom};
    end
  end

  assign out_valid_o = out_valid_q;
  assign work_x_o    = work_x_q;
  assign work_y_o    = work_y_q;
  assign work_w_o    = $signed(work_w_q);
  assign work_h_o    = $signed(work_h_q);

`ifndef SYNTHESIS
  a_fin_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_adv |=> out_valid_o)
    else $error("finish item did not produce a result");

  a_fin_clears_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_adv |=> (max_left == '0) && (max_right == '0) &&
                (max_top == '0) && (max_bottom == '0))
    else $error("side maxima not cleared after finish");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !fin_adv) |=> !out_valid_o)
    else $error("result appeared without a finish item");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stg_valid_q |-> in_ready_o)
    else $error("input not ready with empty stage");

  a_max_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(max_left) && $stable(max_right) &&
             $stable(max_top) && $stable(max_bottom))
    else $error("side maximum changed without an item");
`endif

endmodule

// ===== tb/edge_reservation_workarea_tb.sv =====
// Self-checking testbench: directed and random edge reservations against a predictor.
module edge_reservation_workarea_tb;

  localparam int unsigned CoordW = erw_pkg::CoordW;
  localparam int unsigned SumW = erw_pkg::SumW;
  localparam int unsigned EdgeW = erw_pkg::EdgeW;
  localparam int unsigned OpW = erw_pkg::OpW;
  localparam int unsigned CfgIdxW = erw_pkg::CfgIdxW;
  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned NumCfg = 6;
  localparam int unsigned RandItems = 1950;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned SendIdle [4] = '{0, 73, 0, 29};
  localparam int unsigned RecvStall [4] = '{0, 0, 73, 29};

  typedef struct packed {
    logic [SumW-1:0]         x;
    logic [SumW-1:0]         y;
    logic signed [EdgeW-1:0] w;
    logic signed [EdgeW-1:0] h;
  } work_area_t;

  typedef struct packed {
    logic               is_write;
    logic [CfgIdxW-1:0] idx;
    logic [CoordW-1:0]  wdata;
    logic [OpW-1:0]     op;
    logic [CoordW-1:0]  ext;
    logic [CoordW-1:0]  s0;
    logic [CoordW-1:0]  s1;
    logic               known;
    work_area_t         area;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [OpW-1:0]          operation_i;
  logic [CoordW-1:0]       extent_i;
  logic [CoordW-1:0]       span_start_i;
  logic [CoordW-1:0]       span_end_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [SumW-1:0]         work_x_o;
  logic [SumW-1:0]         work_y_o;
  logic signed [EdgeW-1:0] work_w_o;
  logic signed [EdgeW-1:0] work_h_o;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [CoordW-1:0]       cfg_wdata_i;

  logic [CoordW-1:0] geom [NumCfg];
  logic [CoordW-1:0] side_max [4];
  work_area_t        areas_due [$];
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;

  edge_reservation_workarea uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .extent_i     (extent_i),
    .span_start_i (span_start_i),
    .span_end_i   (span_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .work_x_o     (work_x_o),
    .work_y_o     (work_y_o),
    .work_w_o     (work_w_o),
    .work_h_o     (work_h_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit step_area(input logic [OpW-1:0] op, input logic [CoordW-1:0] ext,
                                   input logic [CoordW-1:0] s0, input logic [CoordW-1:0] s1,
                                   output work_area_t area);
    int ax, ay, aw, ah, rw, rh;
    int base, size, obase, osize, inner, amount, lo, hi, a0, a1, cur;
    int wx, wy, ww, wh;
    bit horiz;
    ax = geom[erw_pkg::CFG_AREA_LEFT];
    ay = geom[erw_pkg::CFG_AREA_TOP];
    aw = geom[erw_pkg::CFG_AREA_WIDTH];
    ah = geom[erw_pkg::CFG_AREA_HEIGHT];
    rw = geom[erw_pkg::CFG_ROOT_WIDTH];
    rh = geom[erw_pkg::CFG_ROOT_HEIGHT];
    area = '0;
    if (op > erw_pkg::OP_BOTTOM) begin
      if (op != erw_pkg::OP_FINISH) return 1'b0;
      wx = ax + int'(side_max[erw_pkg::OP_LEFT]);
      wy = ay + int'(side_max[erw_pkg::OP_TOP]);
      ww = aw - int'(side_max[erw_pkg::OP_LEFT]) - int'(side_max[erw_pkg::OP_RIGHT]);
      wh = ah - int'(side_max[erw_pkg::OP_TOP]) - int'(side_max[erw_pkg::OP_BOTTOM]);
      area.x = wx[SumW-1:0];
      area.y = wy[SumW-1:0];
      area.w = ww[EdgeW-1:0];
      area.h = wh[EdgeW-1:0];
      side_max = '{default: '0};
      return 1'b1;
    end
    horiz = (op == erw_pkg::OP_LEFT) || (op == erw_pkg::OP_RIGHT);
    base = horiz ? ax : ay;
    size = horiz ? aw : ah;
    obase = horiz ? ay : ax;
    osize = horiz ? ah : aw;
    inner = ext;
    if (op == erw_pkg::OP_RIGHT) inner = rw - int'(ext);
    if (op == erw_pkg::OP_BOTTOM) inner = rh - int'(ext);
    amount = ((op == erw_pkg::OP_LEFT) || (op == erw_pkg::OP_TOP)) ?
             inner - base : base + size - inner;
    a0 = s0;
    a1 = s1;
    lo = (a0 > obase) ? a0 : obase;
    hi = (a1 < obase + osize) ? a1 : obase + osize;
    cur = side_max[op[1:0]];
    if (inner >= base && inner <= base + size && hi - lo > 0 && amount > cur) begin
      side_max[op[1:0]] = amount[CoordW-1:0];
    end
    return 1'b0;
  endfunction

  task automatic send_item(input logic [OpW-1:0] op, input logic [CoordW-1:0] ext,
                           input logic [CoordW-1:0] s0, input logic [CoordW-1:0] s1,
                           input logic known, input work_area_t known_area);
    work_area_t area;
    if (step_area(op, ext, s0, s1, area)) begin
      if (known) area = known_area;
      areas_due = {areas_due, area};
    end
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    extent_i = ext;
    span_start_i = s0;
    span_end_i = s1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // hold off until every pending area is out and the input stage has settled
  task automatic drain();
    in_valid_i = 1'b0;
    while (areas_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    geom[idx] = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_item();
    logic [OpW-1:0] op;
    int base, size, obase, osize, root, inner, ext, s0, s1;
    bit horiz;
    if ($urandom_range(99) < 25) begin
      send_item(OpW'($urandom_range(OP_SPARE_HI)), CoordW'($urandom), CoordW'($urandom),
                CoordW'($urandom), 1'b0, '0);
      return;
    end
    op = ($urandom_range(99) < 15) ? erw_pkg::OP_FINISH :
         OpW'($urandom_range(erw_pkg::OP_BOTTOM));
    horiz = (op == erw_pkg::OP_LEFT) || (op == erw_pkg::OP_RIGHT);
    base = horiz ? geom[erw_pkg::CFG_AREA_LEFT] : geom[erw_pkg::CFG_AREA_TOP];
    size = horiz ? geom[erw_pkg::CFG_AREA_WIDTH] : geom[erw_pkg::CFG_AREA_HEIGHT];
    obase = horiz ? geom[erw_pkg::CFG_AREA_TOP] : geom[erw_pkg::CFG_AREA_LEFT];
    osize = horiz ? geom[erw_pkg::CFG_AREA_HEIGHT] : geom[erw_pkg::CFG_AREA_WIDTH];
    root = horiz ? geom[erw_pkg::CFG_ROOT_WIDTH] : geom[erw_pkg::CFG_ROOT_HEIGHT];
    inner = base + int'($urandom_range(size));
    ext = ((op == erw_pkg::OP_RIGHT) || (op == erw_pkg::OP_BOTTOM)) ? root - inner : inner;
    s0 = obase + int'($urandom_range(osize)) - int'($urandom_range(32));
    s1 = s0 + int'($urandom_range(4096));
    send_item(op, CoordW'(ext), CoordW'(s0), CoordW'(s1), 1'b0, '0);
  endtask

  function automatic stim_row_t set_row(input erw_pkg::cfg_idx_e idx,
                                        input logic [CoordW-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.idx = idx;
    row.wdata = data;
    return row;
  endfunction

  function automatic stim_row_t item_row(input logic [OpW-1:0] op, input logic [CoordW-1:0] ext,
                                         input logic [CoordW-1:0] s0,
                                         input logic [CoordW-1:0] s1);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.ext = ext;
    row.s0 = s0;
    row.s1 = s1;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [SumW-1:0] x, input logic [SumW-1:0] y,
                                          input logic signed [EdgeW-1:0] w,
                                          input logic signed [EdgeW-1:0] h);
    stim_row_t row;
    row = item_row(erw_pkg::OP_FINISH, 16'hFFFF, 16'h0000, 16'hFFFF);
    row.known = 1'b1;
    row.area = '{x: x, y: y, w: w, h: h};
    return row;
  endfunction

  task automatic field_check(input string field, input logic signed [EdgeW-1:0] want,
                             input logic signed [EdgeW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    work_area_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (areas_due.size() == 0) begin
        mismatches++;
        $error("work area transfer with none pending: x %0d y %0d w %0d h %0d",
               work_x_o, work_y_o, work_w_o, work_h_o);
      end else begin
        want = areas_due.pop_front();
        field_check("work_x", want.x, work_x_o);
        field_check("work_y", want.y, work_y_o);
        field_check("work_w", want.w, work_w_o);
        field_check("work_h", want.h, work_h_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    logic [CoordW-1:0] g [NumCfg];
    int rw, rh, ax, ay;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = erw_pkg::OP_LEFT;
    extent_i = '0;
    span_start_i = '0;
    span_end_i = '0;
    out_ready_i = 1'b1;
    cfg_we_i = 1'b0;
    cfg_index_i = erw_pkg::CFG_AREA_LEFT;
    cfg_wdata_i = '0;
    geom = '{default: '0};
    side_max = '{default: '0};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    rows = '{
      known_row(17'd0, 17'd0, 18'sd0, 18'sd0),
      set_row(erw_pkg::CFG_AREA_LEFT, 16'd100), set_row(erw_pkg::CFG_AREA_TOP, 16'd50),
      set_row(erw_pkg::CFG_AREA_WIDTH, 16'd800), set_row(erw_pkg::CFG_AREA_HEIGHT, 16'd600),
      set_row(erw_pkg::CFG_ROOT_WIDTH, 16'd1000), set_row(erw_pkg::CFG_ROOT_HEIGHT, 16'd700),
      item_row(erw_pkg::OP_LEFT, 16'd150, 16'd60, 16'd200),
      item_row(erw_pkg::OP_RIGHT, 16'd200, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_TOP, 16'd80, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_BOTTOM, 16'd150, 16'd300, 16'd301),
      known_row(17'd150, 17'd80, 18'sd650, 18'sd470),
      item_row(erw_pkg::OP_LEFT, 16'd99, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_LEFT, 16'd901, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_LEFT, 16'd900, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_RIGHT, 16'hFFFF, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_TOP, 16'd100, 16'd500, 16'd500),
      item_row(erw_pkg::OP_TOP, 16'd100, 16'd600, 16'd400),
      item_row(erw_pkg::OP_TOP, 16'd200, 16'd0, 16'd100),
      item_row(erw_pkg::OP_RIGHT, 16'd900, 16'd0, 16'hFFFF),
      item_row(OP_SPARE_LO, 16'hFFFF, 16'd0, 16'hFFFF),
      item_row(OP_SPARE_HI, 16'hFFFF, 16'd0, 16'hFFFF),
      known_row(17'd900, 17'd50, -18'sd800, 18'sd600),
      known_row(17'd100, 17'd50, 18'sd800, 18'sd600),
      set_row(erw_pkg::CFG_AREA_LEFT, 16'hFFFF), set_row(erw_pkg::CFG_AREA_TOP, 16'd0),
      set_row(erw_pkg::CFG_AREA_WIDTH, 16'hFFFF),
      set_row(erw_pkg::CFG_AREA_HEIGHT, 16'hFFFF),
      set_row(erw_pkg::CFG_ROOT_WIDTH, 16'hFFFF), set_row(erw_pkg::CFG_ROOT_HEIGHT, 16'd0),
      item_row(erw_pkg::OP_LEFT, 16'hFFFF, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_RIGHT, 16'd0, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_TOP, 16'hFFFF, 16'd0, 16'hFFFF),
      item_row(erw_pkg::OP_BOTTOM, 16'd0, 16'hFFFF, 16'd0),
      item_row(erw_pkg::OP_FINISH, 16'd0, 16'hFFFF, 16'd0)
    };
    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        write_reg(rows[i].idx, rows[i].wdata);
      end else begin
        send_item(rows[i].op, rows[i].ext, rows[i].s0, rows[i].s1, rows[i].known, rows[i].area);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) begin
        g = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      end else if (p == 1) begin
        g = '{default: 16'hFFFF};
      end else if (p == 2) begin
        g = '{default: '0};
      end else begin
        rw = $urandom_range(16'hFFFF);
        rh = $urandom_range(16'hFFFF);
        ax = $urandom_range(rw);
        ay = $urandom_range(rh);
        g[erw_pkg::CFG_AREA_LEFT] = CoordW'(ax);
        g[erw_pkg::CFG_AREA_TOP] = CoordW'(ay);
        g[erw_pkg::CFG_AREA_WIDTH] = CoordW'($urandom_range(rw - ax));
        g[erw_pkg::CFG_AREA_HEIGHT] = CoordW'($urandom_range(rh - ay));
        g[erw_pkg::CFG_ROOT_WIDTH] = CoordW'(rw);
        g[erw_pkg::CFG_ROOT_HEIGHT] = CoordW'(rh);
      end
      for (int i = 0; i < NumCfg; i++) write_reg(CfgIdxW'(i), g[i]);
      idle_pct = SendIdle[p % 4];
      stall_pct = RecvStall[p % 4];
      for (int n = 0; n < RandItems / NumPhases; n++) begin
        if (p == 0 && n == RandItems / NumPhases / 2) drain();
        random_item();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/erw_pkg.sv
src/erw_side_max.sv
src/edge_reservation_workarea.sv
tb/edge_reservation_workarea_tb.sv
